/* src/bpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the bright pixel centroid block.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Field widths of the pixel and result transactions.
   localparam int COLOR_W        = 8;
   localparam int POSITION_W     = 21;
   localparam int TOTAL_W        = 25;

   // Configuration port.
   localparam int THRESHOLD_W    = 8;
   localparam int FRAME_SIZE_W   = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT     = 2'd2;

   localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET    = 8'd250;
   localparam logic [FRAME_SIZE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_SIZE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Luma weights in 14-bit fixed point, with the rounding half.
   localparam int LUMA_SUM_W = 23;
   localparam int LUMA_SHIFT = 14;
   localparam logic [LUMA_SUM_W-1:0] LUMA_B     = 23'd1868;
   localparam logic [LUMA_SUM_W-1:0] LUMA_G     = 23'd9617;
   localparam logic [LUMA_SUM_W-1:0] LUMA_R     = 23'd4899;
   localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 23'd8192;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } req_type;

   typedef struct packed {
      logic [POSITION_W-1:0] position_x;
      logic [POSITION_W-1:0] position_y;
      logic [TOTAL_W-1:0]    bright_total;
      logic                  none_found;
   } rsp_type;

   typedef enum logic [1:0] {
      CENT_IDLE,
      CENT_DIV_X,
      CENT_DIV_Y
   } cent_state_type;

endpackage

/* src/bright_pixel_centroid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bright_pixel_centroid
// Centroid of the pixels above a gray threshold in a raster-order BGR frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low. The last pixel of a frame
// starts the centroid division: one shared restoring divider, one quotient bit
// per cycle, works first on the column sum and then on the row sum, while busy
// stays high. The result is then shown for one cycle with rsp_valid; the
// receiver has no way to stall it and must take it.
module bright_pixel_centroid
   import bpc_pkg::*;
#(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int FRACTION_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WEW  = $clog2(MAX_WIDTH + 1);
   localparam int HEW  = $clog2(MAX_HEIGHT + 1);
   localparam int SZ0  = (WEW > HEW) ? WEW : HEW;
   localparam int CMPW = (SZ0 > FRAME_SIZE_W) ? SZ0 : FRAME_SIZE_W;
   localparam int NCW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int PW   = (CW > RW) ? CW : RW;
   localparam int SW   = PW + NCW;
   localparam int NW   = SW + FRACTION_BITS;
   localparam int IW   = $clog2(NW);
   localparam int ADDW = NW + 1;

   cent_state_type state_ff, state_in;

   logic [THRESHOLD_W-1:0]  threshold_ff, threshold_in;
   logic [FRAME_SIZE_W-1:0] width_ff, width_in;
   logic [FRAME_SIZE_W-1:0] height_ff, height_in;

   logic [CW-1:0]  column_ff, column_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [SW-1:0]  sum_x_ff, sum_x_in;
   logic [SW-1:0]  sum_y_ff, sum_y_in;
   logic [NCW-1:0] count_ff, count_in;

   // Divider and frame-end hold registers.
   logic [NW-1:0]   num_ff, num_in;
   logic [NCW-1:0]  rem_ff, rem_in;
   logic [NCW-1:0]  div_count_ff, div_count_in;
   logic [SW-1:0]   hold_y_ff, hold_y_in;
   logic [NW-1:0]   quot_x_ff, quot_x_in;
   logic [CMPW-1:0] hold_w_ff, hold_w_in;
   logic [CMPW-1:0] hold_h_ff, hold_h_in;
   logic [IW-1:0]   step_ff, step_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Sequencer controls.
   logic load_x;
   logic load_y;
   logic div_step;
   logic finish;

   logic                  accept;
   logic [LUMA_SUM_W-1:0] luma_sum;
   logic [COLOR_W-1:0]    gray;
   logic                  bright;
   logic [CMPW-1:0]       width_ext, height_ext;
   logic [CMPW-1:0]       eff_w, eff_h;
   logic                  row_end, frame_end;
   logic [SW-1:0]         sum_x_upd, sum_y_upd;
   logic [NCW-1:0]        count_upd;
   logic [NCW:0]          rem_shift;
   logic                  rem_ge;
   logic [NW-1:0]         num_step;
   logic [ADDW-1:0]       pos_x_wide, pos_y_wide;

   assign accept = start && (state_ff == CENT_IDLE);
   assign busy   = (state_ff != CENT_IDLE);

   // Gray level and bright test.
   assign luma_sum = LUMA_B * LUMA_SUM_W'(req_data.blue)
                   + LUMA_G * LUMA_SUM_W'(req_data.green)
                   + LUMA_R * LUMA_SUM_W'(req_data.red)
                   + LUMA_ROUND;
   assign gray   = luma_sum[LUMA_SHIFT +: COLOR_W];
   assign bright = gray > threshold_ff;

   // A size of zero counts as one; a size above the maximum saturates.
   assign width_ext  = CMPW'(width_ff);
   assign height_ext = CMPW'(height_ff);
   always_comb begin
      if (width_ext == '0) begin
         eff_w = CMPW'(1);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         eff_w = CMPW'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      if (height_ext == '0) begin
         eff_h = CMPW'(1);
      end else if (height_ext > CMPW'(MAX_HEIGHT)) begin
         eff_h = CMPW'(MAX_HEIGHT);
      end else begin
         eff_h = height_ext;
      end
   end

   assign row_end   = CMPW'(column_ff) >= (eff_w - CMPW'(1));
   assign frame_end = row_end && (CMPW'(row_ff) >= (eff_h - CMPW'(1)));

   assign sum_x_upd = sum_x_ff + (bright ? SW'(column_ff) : '0);
   assign sum_y_upd = sum_y_ff + (bright ? SW'(row_ff) : '0);
   assign count_upd = count_ff + NCW'(bright);

   // One restoring division step.
   assign rem_shift = {rem_ff, num_ff[NW-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_count_ff};
   assign num_step  = {num_ff[NW-2:0], rem_ge};

   // The row quotient is complete in num_step on the last step.
   always_comb begin
      if (div_count_ff == '0) begin
         pos_x_wide = (ADDW'(hold_w_ff) << FRACTION_BITS) - (ADDW'(1) << FRACTION_BITS);
         pos_y_wide = (ADDW'(hold_h_ff) << FRACTION_BITS) - (ADDW'(1) << FRACTION_BITS);
      end else begin
         pos_x_wide = ADDW'(quot_x_ff) + (ADDW'(hold_w_ff) << FRACTION_BITS);
         pos_y_wide = ADDW'(num_step) + (ADDW'(hold_h_ff) << FRACTION_BITS);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CENT_IDLE: begin
            if (accept && frame_end) begin
               state_in = CENT_DIV_X;
            end
         end
         CENT_DIV_X: begin
            if (step_ff == '0) begin
               state_in = CENT_DIV_Y;
            end
         end
         CENT_DIV_Y: begin
            if (step_ff == '0) begin
               state_in = CENT_IDLE;
            end
         end
         default: begin
            state_in = CENT_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      load_x   = 1'b0;
      load_y   = 1'b0;
      div_step = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         CENT_IDLE: begin
            load_x = accept && frame_end;
         end
         CENT_DIV_X: begin
            div_step = 1'b1;
            load_y   = (step_ff == '0);
         end
         CENT_DIV_Y: begin
            div_step = 1'b1;
            finish   = (step_ff == '0);
         end
         default: begin
            load_x = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BRIGHT_THRESHOLD: threshold_in = csr_data[THRESHOLD_W-1:0];
            CSR_FRAME_WIDTH:      width_in     = csr_data[FRAME_SIZE_W-1:0];
            CSR_FRAME_HEIGHT:     height_in    = csr_data[FRAME_SIZE_W-1:0];
            default:              threshold_in = threshold_ff;
         endcase
      end

      column_in = column_ff;
      row_in    = row_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      count_in  = count_ff;
      if (accept) begin
         if (frame_end) begin
            column_in = '0;
            row_in    = '0;
            sum_x_in  = '0;
            sum_y_in  = '0;
            count_in  = '0;
         end else begin
            sum_x_in = sum_x_upd;
            sum_y_in = sum_y_upd;
            count_in = count_upd;
            if (row_end) begin
               column_in = '0;
               row_in    = row_ff + RW'(1);
            end else begin
               column_in = column_ff + CW'(1);
            end
         end
      end

      num_in       = num_ff;
      rem_in       = rem_ff;
      div_count_in = div_count_ff;
      hold_y_in    = hold_y_ff;
      quot_x_in    = quot_x_ff;
      hold_w_in    = hold_w_ff;
      hold_h_in    = hold_h_ff;
      step_in      = step_ff;
      if (load_x) begin
         num_in       = NW'(sum_x_upd) << FRACTION_BITS;
         rem_in       = '0;
         div_count_in = count_upd;
         hold_y_in    = sum_y_upd;
         hold_w_in    = eff_w;
         hold_h_in    = eff_h;
         step_in      = IW'(NW - 1);
      end else if (load_y) begin
         num_in    = NW'(hold_y_ff) << FRACTION_BITS;
         rem_in    = '0;
         quot_x_in = num_step;
         step_in   = IW'(NW - 1);
      end else if (div_step) begin
         num_in  = num_step;
         rem_in  = rem_ge ? NCW'(rem_shift - {1'b0, div_count_ff}) : rem_shift[NCW-1:0];
         step_in = step_ff - IW'(1);
      end

      rsp_valid_in = finish;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_data_in.position_x   = POSITION_W'(pos_x_wide);
         rsp_data_in.position_y   = POSITION_W'(pos_y_wide);
         rsp_data_in.bright_total = TOTAL_W'(div_count_ff);
         rsp_data_in.none_found   = (div_count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CENT_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= FRAME_WIDTH_RESET;
         height_ff    <= FRAME_HEIGHT_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      div_count_ff <= div_count_in;
      hold_y_ff    <= hold_y_in;
      quot_x_ff    <= quot_x_in;
      hold_w_ff    <= hold_w_in;
      hold_h_ff    <= hold_h_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/tb_bright_pixel_centroid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bright_pixel_centroid
// Self-checking testbench for the bright pixel centroid block.
// ----------------------------------------------------------------------------
// A directed table covers the reset threshold, the threshold extremes, frame
// sizes of zero, sizes shrunk in the middle of a frame and the unused register
// index. Random frames of small sizes follow, then partial frames at the
// saturated sizes. Every accepted pixel runs through a local centroid model,
// and each result transaction is compared with the oldest expected centroid.
module tb_bright_pixel_centroid;
   import bpc_pkg::*;

   localparam int MAX_SIZE      = 4096;
   localparam int FRAC_BITS     = 8;
   localparam int RANDOM_PIXELS = 2000;
   localparam int LARGE_PIXELS  = 100;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 200;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {
      STEP_PIXEL,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type          kind;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0]  csr_value;
      req_type                pixel;
      bit                     typed;
      rsp_type                result;
   } step_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Local copy of the registers and the frame accumulators.
   logic [THRESHOLD_W-1:0]  model_threshold;
   logic [FRAME_SIZE_W-1:0] model_width;
   logic [FRAME_SIZE_W-1:0] model_height;
   int unsigned             column_count;
   int unsigned             row_count;
   longint unsigned         column_sum;
   longint unsigned         row_sum;
   longint unsigned         bright_count;

   rsp_type  centroid_queue[$];
   step_type directed_steps[$];
   int       error_count = 0;
   int       cycle_count = 0;
   int       idle_pct = 20;

   bright_pixel_centroid #(
      .MAX_WIDTH     (MAX_SIZE),
      .MAX_HEIGHT    (MAX_SIZE),
      .FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int unsigned size_in_use(input logic [FRAME_SIZE_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SIZE) return MAX_SIZE;
      return value;
   endfunction

   function automatic logic [POSITION_W-1:0] mean_position(input longint unsigned sum,
                                                           input longint unsigned count,
                                                           input int unsigned size);
      longint unsigned base;
      base = size;
      base = base << FRAC_BITS;
      // A frame without bright pixels counts as a mean of minus one.
      if (count == 0) return POSITION_W'(base - (64'd1 << FRAC_BITS));
      return POSITION_W'(((sum << FRAC_BITS) / count) + base);
   endfunction

   // Advances the frame accumulators by one pixel; returns 1 at the end of a frame.
   function automatic bit centroid_step(input req_type pixel, output rsp_type result);
      int unsigned w;
      int unsigned h;
      int unsigned gray;
      bit          row_end;
      w = size_in_use(model_width);
      h = size_in_use(model_height);
      gray = 32'(LUMA_B) * pixel.blue + 32'(LUMA_G) * pixel.green
             + 32'(LUMA_R) * pixel.red + 32'(LUMA_ROUND);
      gray = gray >> LUMA_SHIFT;
      result = '0;
      if (gray > model_threshold) begin
         column_sum += column_count;
         row_sum += row_count;
         bright_count++;
      end
      row_end = column_count >= w - 1;
      if (row_end && row_count >= h - 1) begin
         result.position_x = mean_position(column_sum, bright_count, w);
         result.position_y = mean_position(row_sum, bright_count, h);
         result.bright_total = TOTAL_W'(bright_count);
         result.none_found = (bright_count == 0);
         column_count = 0;
         row_count = 0;
         column_sum = 0;
         row_sum = 0;
         bright_count = 0;
         return 1'b1;
      end
      if (row_end) begin
         column_count = 0;
         row_count++;
      end else begin
         column_count++;
      end
      return 1'b0;
   endfunction

   function automatic req_type random_pixel();
      req_type pixel;
      int      level;
      pixel.blue = COLOR_W'($urandom());
      pixel.green = COLOR_W'($urandom());
      pixel.red = COLOR_W'($urandom());
      case ($urandom_range(0, 5))
         0: begin
            // Equal components give a gray level equal to the component.
            level = int'(model_threshold) + int'($urandom_range(0, 4)) - 2;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            pixel = {3{COLOR_W'(level)}};
         end
         1: pixel = '1;
         2: pixel = '0;
         3: begin
            pixel.green = '0;
            pixel.red = '0;
         end
         default: ;
      endcase
      return pixel;
   endfunction

   function automatic void add_pixel(input logic [COLOR_W-1:0] blue,
                                     input logic [COLOR_W-1:0] green,
                                     input logic [COLOR_W-1:0] red,
                                     input bit typed = 1'b0,
                                     input logic [POSITION_W-1:0] x = '0,
                                     input logic [POSITION_W-1:0] y = '0,
                                     input logic [TOTAL_W-1:0] total = '0,
                                     input logic none = 1'b0);
      step_type step;
      step.kind = STEP_PIXEL;
      step.csr_index = '0;
      step.csr_value = '0;
      step.pixel.blue = blue;
      step.pixel.green = green;
      step.pixel.red = red;
      step.typed = typed;
      step.result.position_x = x;
      step.result.position_y = y;
      step.result.bright_total = total;
      step.result.none_found = none;
      directed_steps.push_back(step);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      step_type step;
      step.kind = STEP_CSR;
      step.csr_index = index;
      step.csr_value = value;
      step.pixel = '0;
      step.typed = 1'b0;
      step.result = '0;
      directed_steps.push_back(step);
   endfunction

   // Drops start and waits until every expected centroid is out and busy is low.
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (centroid_queue.size() != 0 || busy);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_data = value;
      @(posedge clock);
      case (index)
         CSR_BRIGHT_THRESHOLD: model_threshold = value[THRESHOLD_W-1:0];
         CSR_FRAME_WIDTH:      model_width = value;
         CSR_FRAME_HEIGHT:     model_height = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Start is left high after the transaction so back-to-back pixels need no gap.
   task automatic send_pixel(input req_type pixel, input bit typed,
                             input rsp_type typed_result);
      rsp_type predicted;
      if ($urandom_range(1, 100) <= idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_data = pixel;
      do @(posedge clock); while (busy);
      if (centroid_step(pixel, predicted))
         centroid_queue.push_back(typed ? typed_result : predicted);
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid === 1'b1) begin
         if (centroid_queue.size() == 0) begin
            $error("unexpected centroid transaction: %p", rsp_data);
            error_count++;
         end else begin
            expected = centroid_queue.pop_front();
            if (rsp_data.position_x !== expected.position_x) begin
               $error("position_x: expected %0d, actual %0d",
                      expected.position_x, rsp_data.position_x);
               error_count++;
            end
            if (rsp_data.position_y !== expected.position_y) begin
               $error("position_y: expected %0d, actual %0d",
                      expected.position_y, rsp_data.position_y);
               error_count++;
            end
            if (rsp_data.bright_total !== expected.bright_total) begin
               $error("bright_total: expected %0d, actual %0d",
                      expected.bright_total, rsp_data.bright_total);
               error_count++;
            end
            if (rsp_data.none_found !== expected.none_found) begin
               $error("none_found: expected %0d, actual %0d",
                      expected.none_found, rsp_data.none_found);
               error_count++;
            end
         end
      end
   end

   initial begin
      int                    sent;
      int                    level;
      logic [CSR_DATA_W-1:0] value;

      start = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      model_threshold = THRESHOLD_RESET;
      model_width = FRAME_WIDTH_RESET;
      model_height = FRAME_HEIGHT_RESET;
      column_count = 0;
      row_count = 0;
      column_sum = 0;
      row_sum = 0;
      bright_count = 0;

      // Three pixels of the reset frame size, then the width shrinks below the
      // current column, so the next pixel closes the frame.
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_csr(CSR_FRAME_WIDTH, 13'd2);
      add_csr(CSR_FRAME_HEIGHT, 13'd1);
      add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 21'd768, 21'd256, 25'd2, 1'b0);
      // One pixel per frame from here until the frame size grows again.
      add_csr(CSR_FRAME_WIDTH, 13'd1);
      add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 21'd0, 21'd0, 25'd0, 1'b1);
      add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 21'd256, 21'd256, 25'd1, 1'b0);
      add_csr(CSR_BRIGHT_THRESHOLD, 13'd255);
      add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 21'd0, 21'd0, 25'd0, 1'b1);
      add_csr(CSR_BRIGHT_THRESHOLD, 13'd0);
      add_pixel(8'd1, 8'd0, 8'd0, 1'b1, 21'd0, 21'd0, 25'd0, 1'b1);
      add_pixel(8'd0, 8'd1, 8'd0);
      add_pixel(8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd255);
      // A write to the unused index must leave every register as it was.
      add_csr(CSR_UNUSED, 13'h1fff);
      add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 21'd0, 21'd0, 25'd0, 1'b1);
      add_csr(CSR_FRAME_WIDTH, 13'd0);
      add_csr(CSR_FRAME_HEIGHT, 13'd0);
      add_pixel(8'd255, 8'd255, 8'd255, 1'b1, 21'd256, 21'd256, 25'd1, 1'b0);
      // The height shrinks while the row counter is already past the new last row.
      add_csr(CSR_FRAME_WIDTH, 13'd2);
      add_csr(CSR_FRAME_HEIGHT, 13'd4);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_csr(CSR_FRAME_HEIGHT, 13'd2);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd255, 8'd255);
      // Upper data bits are dropped for the threshold, leaving 128.
      add_csr(CSR_BRIGHT_THRESHOLD, 13'h1f80);
      add_csr(CSR_FRAME_WIDTH, 13'd1);
      add_csr(CSR_FRAME_HEIGHT, 13'd1);
      add_pixel(8'd128, 8'd128, 8'd128, 1'b1, 21'd0, 21'd0, 25'd0, 1'b1);
      add_pixel(8'd129, 8'd129, 8'd129, 1'b1, 21'd256, 21'd256, 25'd1, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            write_csr(directed_steps[i].csr_index, directed_steps[i].csr_value);
         else
            send_pixel(directed_steps[i].pixel, directed_steps[i].typed,
                       directed_steps[i].result);
      end

      // Each phase picks new settings without waiting for the open frame to
      // finish, so size changes often land in the middle of a frame.
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if (sent < RANDOM_PIXELS / 3) idle_pct = 20;
         else if (sent < 2 * RANDOM_PIXELS / 3) idle_pct = 54;
         else idle_pct = 0;
         case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 255;
            default: level = $urandom_range(0, 255);
         endcase
         value = CSR_DATA_W'($urandom());
         value[THRESHOLD_W-1:0] = THRESHOLD_W'(level);
         write_csr(CSR_BRIGHT_THRESHOLD, value);
         write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(0, 6)));
         write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(0, 5)));
         repeat ($urandom_range(40, 160)) begin
            if ($urandom_range(0, 63) == 0) wait_idle();
            send_pixel(random_pixel(), 1'b0, '0);
            sent++;
         end
      end

      // Part of a row at the saturated width, then part of a column at the
      // saturated height; each is closed by the one by one frame that follows.
      for (int k = 0; k < 2; k++) begin
         write_csr(CSR_FRAME_WIDTH, 13'd1);
         write_csr(CSR_FRAME_HEIGHT, 13'd1);
         // A one by one frame closes whatever frame is still open.
         send_pixel(random_pixel(), 1'b0, '0);
         write_csr(CSR_BRIGHT_THRESHOLD, CSR_DATA_W'($urandom_range(0, 255)));
         write_csr(CSR_FRAME_WIDTH, (k == 0) ? 13'd8191 : 13'd1);
         write_csr(CSR_FRAME_HEIGHT, (k == 0) ? 13'd1 : 13'd4096);
         repeat (LARGE_PIXELS) send_pixel(random_pixel(), 1'b0, '0);
      end
      write_csr(CSR_FRAME_WIDTH, 13'd1);
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel(random_pixel(), 1'b0, '0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/bpc_pkg.sv
src/bright_pixel_centroid.sv
verif/tb_bright_pixel_centroid.sv
